// ===== rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  // ARP header constants for Ethernet / IPv4.
  localparam logic [15:0] HTYPE_ETH = 16'h0001;
  localparam logic [15:0] PTYPE_IP4 = 16'h0800;
  localparam logic [15:0] OPER_REQ  = 16'h0001;
  localparam logic [15:0] OPER_REP  = 16'h0002;
  localparam logic [7:0]  HW_LEN    = 8'd6;
  localparam logic [7:0]  PROTO_LEN = 8'd4;
  localparam logic [15:0] HDR_BYTES = 16'd28;

  localparam logic [1:0]  FRAME_REQ = 2'd1;
  localparam logic [1:0]  FRAME_REP = 2'd2;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // Command codes on the input word.
  localparam logic [1:0] CMD_RECEIVE = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_RESOLVE = 2'd2;

  // Register index of the own IPv4 address.
  localparam logic REG_OWN_IP = 1'b0;

  typedef enum logic [3:0] {
    ST_REPLY_STORED = 4'd0,
    ST_REQ_ANSWERED = 4'd1,
    ST_TOO_SHORT    = 4'd2,
    ST_BAD_FORMAT   = 4'd3,
    ST_UNKNOWN_OPER = 4'd4,
    ST_LOOKUP_HIT   = 4'd5,
    ST_LOOKUP_MISS  = 4'd6,
    ST_RESOLVE_HIT  = 4'd7,
    ST_REQUEST_SENT = 4'd8
  } status_t;

  // What an accepted word turns into once it has been classified.
  typedef enum logic [2:0] {
    OP_STORE_REQ,
    OP_STORE_REP,
    OP_SHORT,
    OP_BAD,
    OP_UNKNOWN,
    OP_LOOKUP,
    OP_RESOLVE
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  dev;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/arp_cache_and_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A command that searches the cache scans the entries in slot order and stops at the first
// match; a rejected receive word skips the scan. Command 3 is taken and dropped. The scan
// reads one entry per cycle through the single read port. A new word is held off by busy
// until the last one is finished; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the cache and clears the own address register.

module arp_cache_and_responder
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  // Command input.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [1:0]  in_device,
  input  wire logic [15:0] in_packet_length,
  input  wire logic [15:0] in_hw_type,
  input  wire logic [15:0] in_proto_type,
  input  wire logic [7:0]  in_hw_len,
  input  wire logic [7:0]  in_proto_len,
  input  wire logic [15:0] in_arp_oper,
  input  wire logic [47:0] in_sender_mac,
  input  wire logic [31:0] in_sender_ip,
  input  wire logic [31:0] in_target_ip,
  input  wire logic [31:0] in_now,

  // Result output.
  output logic             out_valid,
  output logic [3:0]       out_status,
  output logic             out_send_frame,
  output logic [1:0]       out_frame_oper,
  output logic [47:0]      out_frame_dest_mac,
  output logic [47:0]      out_frame_target_mac,
  output logic [31:0]      out_frame_sender_ip,
  output logic [31:0]      out_frame_target_ip,
  output logic [47:0]      out_found_mac
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // ---------------------------------------------------------------------------
  // Configuration register. Only the own address register exists; the word at
  // byte address 4 and above reads as zero and ignores writes.
  // ---------------------------------------------------------------------------
  logic [31:0] own_ip_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OWN_IP);
  assign prdata = (paddr[2] == REG_OWN_IP) ? own_ip_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_wr) begin
      own_ip_r <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry memory.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [ENTRIES-1:0] valid;

  arpc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .valid   (valid)
  );

  // ---------------------------------------------------------------------------
  // Word classification at the accepting edge. A receive word is sorted into
  // short, malformed, unknown operation, or one of the two storing cases.
  // ---------------------------------------------------------------------------
  logic accept;
  op_t  in_op;
  logic in_drop;
  logic hdr_ok;

  assign accept = start && !busy;
  assign hdr_ok = (in_hw_type == HTYPE_ETH) && (in_proto_type == PTYPE_IP4) &&
                  (in_hw_len == HW_LEN) && (in_proto_len == PROTO_LEN);

  always_comb begin
    in_op   = OP_LOOKUP;
    in_drop = 1'b0;
    priority if (in_command == CMD_RECEIVE) begin
      priority if (in_packet_length < HDR_BYTES) begin
        in_op = OP_SHORT;
      end else if (!hdr_ok) begin
        in_op = OP_BAD;
      end else if (in_arp_oper == OPER_REQ) begin
        in_op = OP_STORE_REQ;
      end else if (in_arp_oper == OPER_REP) begin
        in_op = OP_STORE_REP;
      end else begin
        in_op = OP_UNKNOWN;
      end
    end else if (in_command == CMD_LOOKUP) begin
      in_op = OP_LOOKUP;
    end else if (in_command == CMD_RESOLVE) begin
      in_op = OP_RESOLVE;
    end else begin
      // The unused command code is taken and produces nothing.
      in_drop = 1'b1;
    end
  end

  // Whether the classified word needs a pass over the cache.
  logic in_scan;
  assign in_scan = (in_op == OP_STORE_REQ) || (in_op == OP_STORE_REP) ||
                   (in_op == OP_LOOKUP) || (in_op == OP_RESOLVE);

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  // Latched word.
  op_t         op_r;
  logic [1:0]  dev_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r;
  logic [31:0] tip_r;
  logic [31:0] now_r;

  // Scan pipeline: rd_idx_r is the next address issued, chk_* the entry whose
  // read data is present this cycle.
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;

  // Search results.
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [47:0]      hit_mac_r, hit_mac_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             old_found_r, old_found_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic [31:0]      old_stamp_r, old_stamp_nxt;

  logic        is_store;
  logic [31:0] key_ip;
  logic        ev_valid;
  logic        ev_match;
  logic        scan_done;

  assign is_store  = (op_r == OP_STORE_REQ) || (op_r == OP_STORE_REP);
  assign key_ip    = is_store ? sip_r : tip_r;
  assign ev_valid  = chk_vld_r && valid[chk_idx_r];
  assign ev_match  = ev_valid && (rd_data.dev == dev_r) && (rd_data.ip == key_ip);
  assign scan_done = chk_vld_r && (ev_match || (chk_idx_r == IDX_LAST));
  assign rd_addr   = rd_idx_r[IDX_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_drop) begin
          state_nxt = in_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Scan datapath.
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_mac_nxt    = hit_mac_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    old_found_nxt  = old_found_r;
    old_idx_nxt    = old_idx_r;
    old_stamp_nxt  = old_stamp_r;
    unique case (state_r)
      S_IDLE: begin
        rd_idx_nxt     = '0;
        chk_vld_nxt    = 1'b0;
        hit_nxt        = 1'b0;
        free_found_nxt = 1'b0;
        old_found_nxt  = 1'b0;
        old_stamp_nxt  = '1;
      end
      S_SCAN: begin
        if (rd_idx_r < CNT_END) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (ev_match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = chk_idx_r;
          hit_mac_nxt = rd_data.mac;
        end else if (chk_vld_r) begin
          if (!ev_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          // Strict compare keeps the lowest index on a tie; a stamp at its
          // maximum never qualifies, so slot 0 is the fallback.
          if (ev_valid && (rd_data.stamp < old_stamp_r)) begin
            old_found_nxt = 1'b1;
            old_idx_nxt   = chk_idx_r;
            old_stamp_nxt = rd_data.stamp;
          end
        end
      end
      S_FINISH: begin
        chk_vld_nxt = 1'b0;
      end
      default: begin
        chk_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_mac_r    <= hit_mac_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    old_found_r  <= old_found_nxt;
    old_idx_r    <= old_idx_nxt;
    old_stamp_r  <= old_stamp_nxt;
    if (accept) begin
      op_r   <= in_op;
      dev_r  <= in_device;
      smac_r <= in_sender_mac;
      sip_r  <= in_sender_ip;
      tip_r  <= in_target_ip;
      now_r  <= in_now;
    end
  end

  assign busy = (state_r != S_IDLE);

  // ---------------------------------------------------------------------------
  // Write-back. A matching entry is rewritten in place; its device and address
  // are the key, so writing the whole row leaves them as they were.
  // ---------------------------------------------------------------------------
  always_comb begin
    wr_en         = (state_r == S_FINISH) && is_store;
    wr_data.dev   = dev_r;
    wr_data.ip    = sip_r;
    wr_data.mac   = smac_r;
    wr_data.stamp = now_r;
    priority if (hit_r) begin
      wr_addr = hit_idx_r;
    end else if (free_found_r) begin
      wr_addr = free_idx_r;
    end else if (old_found_r) begin
      wr_addr = old_idx_r;
    end else begin
      wr_addr = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Loaded in the finishing cycle and shown for one cycle.
  // ---------------------------------------------------------------------------
  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic        send_r, send_nxt;
  logic [1:0]  foper_r, foper_nxt;
  logic [47:0] fdmac_r, fdmac_nxt;
  logic [47:0] ftmac_r, ftmac_nxt;
  logic [31:0] fsip_r, fsip_nxt;
  logic [31:0] ftip_r, ftip_nxt;
  logic [47:0] found_r, found_nxt;

  always_comb begin
    out_valid_nxt = (state_r == S_FINISH);
    status_nxt    = ST_REPLY_STORED;
    send_nxt      = 1'b0;
    foper_nxt     = '0;
    fdmac_nxt     = '0;
    ftmac_nxt     = '0;
    fsip_nxt      = '0;
    ftip_nxt      = '0;
    found_nxt     = '0;
    unique case (op_r)
      OP_STORE_REQ: begin
        // Answer the requester; the target address is not checked against ours.
        status_nxt = ST_REQ_ANSWERED;
        send_nxt   = 1'b1;
        foper_nxt  = FRAME_REP;
        fdmac_nxt  = smac_r;
        ftmac_nxt  = smac_r;
        fsip_nxt   = tip_r;
        ftip_nxt   = sip_r;
      end
      OP_STORE_REP: status_nxt = ST_REPLY_STORED;
      OP_SHORT:     status_nxt = ST_TOO_SHORT;
      OP_BAD:       status_nxt = ST_BAD_FORMAT;
      OP_UNKNOWN:   status_nxt = ST_UNKNOWN_OPER;
      OP_LOOKUP: begin
        if (hit_r) begin
          status_nxt = ST_LOOKUP_HIT;
          found_nxt  = hit_mac_r;
        end else begin
          status_nxt = ST_LOOKUP_MISS;
        end
      end
      OP_RESOLVE: begin
        if (hit_r) begin
          status_nxt = ST_RESOLVE_HIT;
          found_nxt  = hit_mac_r;
        end else begin
          // Broadcast request for the unresolved address.
          status_nxt = ST_REQUEST_SENT;
          send_nxt   = 1'b1;
          foper_nxt  = FRAME_REQ;
          fdmac_nxt  = MAC_BCAST;
          fsip_nxt   = own_ip_r;
          ftip_nxt   = tip_r;
        end
      end
      default: status_nxt = ST_REPLY_STORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH) begin
      status_r <= status_nxt;
      send_r   <= send_nxt;
      foper_r  <= foper_nxt;
      fdmac_r  <= fdmac_nxt;
      ftmac_r  <= ftmac_nxt;
      fsip_r   <= fsip_nxt;
      ftip_r   <= ftip_nxt;
      found_r  <= found_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_send_frame       = send_r;
  assign out_frame_oper       = foper_r;
  assign out_frame_dest_mac   = fdmac_r;
  assign out_frame_target_mac = ftmac_r;
  assign out_frame_sender_ip  = fsip_r;
  assign out_frame_target_ip  = ftip_r;
  assign out_found_mac        = found_r;

endmodule

`default_nettype wire

// ===== rtl/arpc_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arpc_table
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 8,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output entry_t                  rd_data,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  entry_t                  wr_data,
  output logic [ENTRIES-1:0]      valid
);

  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits live in flops so that reset empties the cache at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign valid = valid_r;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the ARP cache and responder.
// Words go in on the start/busy command handshake and are predicted as they
// are accepted. Every result strobe is compared field by field with the
// oldest prediction still pending.
module testbench;
  import arpc_pkg::*;

  localparam int CACHE_ENTRIES = 8;
  // The margin after the last result only adds some slack before the sender moves on.
  localparam int SETTLE_CYCLES = CACHE_ENTRIES + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS = 210;
  localparam int KEYS = 16;

  // The package has no name for the unused command code.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] OWN_IP_ADDR = {REG_OWN_IP, 2'b00};

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  device;
    logic [15:0] packet_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_oper;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] now;
  } arp_word_t;

  typedef struct packed {
    status_t     status;
    logic        send_frame;
    logic [1:0]  frame_oper;
    logic [47:0] frame_dest_mac;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_sender_ip;
    logic [31:0] frame_target_ip;
    logic [47:0] found_mac;
  } arp_result_t;

  // One row of the directed stimulus. When typed is set, the result in the
  // row is what the block must return; otherwise the cache model decides.
  typedef struct packed {
    arp_word_t   word;
    logic        typed;
    arp_result_t fixed;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [1:0]  in_device;
  logic [15:0] in_packet_length;
  logic [15:0] in_hw_type;
  logic [15:0] in_proto_type;
  logic [7:0]  in_hw_len;
  logic [7:0]  in_proto_len;
  logic [15:0] in_arp_oper;
  logic [47:0] in_sender_mac;
  logic [31:0] in_sender_ip;
  logic [31:0] in_target_ip;
  logic [31:0] in_now;
  logic        out_valid;
  logic [3:0]  out_status;
  logic        out_send_frame;
  logic [1:0]  out_frame_oper;
  logic [47:0] out_frame_dest_mac;
  logic [47:0] out_frame_target_mac;
  logic [31:0] out_frame_sender_ip;
  logic [31:0] out_frame_target_ip;
  logic [47:0] out_found_mac;

  arp_cache_and_responder #(
    .ENTRIES(CACHE_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_device(in_device),
    .in_packet_length(in_packet_length),
    .in_hw_type(in_hw_type),
    .in_proto_type(in_proto_type),
    .in_hw_len(in_hw_len),
    .in_proto_len(in_proto_len),
    .in_arp_oper(in_arp_oper),
    .in_sender_mac(in_sender_mac),
    .in_sender_ip(in_sender_ip),
    .in_target_ip(in_target_ip),
    .in_now(in_now),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_send_frame(out_send_frame),
    .out_frame_oper(out_frame_oper),
    .out_frame_dest_mac(out_frame_dest_mac),
    .out_frame_target_mac(out_frame_target_mac),
    .out_frame_sender_ip(out_frame_sender_ip),
    .out_frame_target_ip(out_frame_target_ip),
    .out_found_mac(out_found_mac)
  );

  // Shadow copy of the cache and of the own address, updated as words are
  // accepted.
  logic        cache_valid [CACHE_ENTRIES];
  logic [1:0]  cache_dev   [CACHE_ENTRIES];
  logic [31:0] cache_ip    [CACHE_ENTRIES];
  logic [47:0] cache_mac   [CACHE_ENTRIES];
  logic [31:0] cache_stamp [CACHE_ENTRIES];
  logic [31:0] own_ip_shadow;

  arp_result_t pending_results[$];
  dir_row_t    dir_rows[$];

  // Pool of (device, address) keys that random words mostly draw from, so
  // that hits, refreshes and evictions happen often.
  logic [1:0]  key_dev [KEYS];
  logic [31:0] key_ip  [KEYS];
  logic [31:0] tick;

  int mismatch_count;
  int results_seen;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: result %0d mismatch on %s: got %0h, wanted %0h",
             $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Returns the slot that holds the key, or -1 on a miss.
  function automatic int cache_index_of(input logic [1:0] dev, input logic [31:0] ip);
    int i;
    for (i = 0; i < CACHE_ENTRIES; i++)
      if (cache_valid[i] && cache_dev[i] == dev && cache_ip[i] == ip)
        return i;
    return -1;
  endfunction

  // A matching entry is refreshed in place. Otherwise the lowest free slot
  // is taken, then the valid entry with the smallest stamp (lowest index on
  // a tie). When every stamp is at its maximum no entry is strictly below
  // the start value, and slot 0 is overwritten.
  function automatic void cache_store(input logic [1:0] dev, input logic [31:0] ip,
                                      input logic [47:0] mac, input logic [31:0] stamp);
    int i;
    int free_slot;
    int oldest;
    int victim;
    logic [31:0] oldest_stamp;
    free_slot = -1;
    oldest = -1;
    oldest_stamp = '1;
    for (i = 0; i < CACHE_ENTRIES; i++) begin
      if (cache_valid[i] && cache_dev[i] == dev && cache_ip[i] == ip) begin
        cache_mac[i] = mac;
        cache_stamp[i] = stamp;
        return;
      end
      if (!cache_valid[i] && free_slot < 0)
        free_slot = i;
      if (cache_valid[i] && cache_stamp[i] < oldest_stamp) begin
        oldest_stamp = cache_stamp[i];
        oldest = i;
      end
    end
    victim = (free_slot >= 0) ? free_slot : ((oldest >= 0) ? oldest : 0);
    cache_valid[victim] = 1'b1;
    cache_dev[victim] = dev;
    cache_ip[victim] = ip;
    cache_mac[victim] = mac;
    cache_stamp[victim] = stamp;
  endfunction

  // Works out the result of one accepted word and applies its effect on the
  // cache. Returns 0 for a word that yields no result.
  function automatic logic predict_response(input arp_word_t w, output arp_result_t r);
    int slot;
    r = '0;
    if (w.command == CMD_UNUSED)
      return 1'b0;
    if (w.command == CMD_RECEIVE) begin
      if (w.packet_length < HDR_BYTES) begin
        r.status = ST_TOO_SHORT;
      end else if (w.hw_type != HTYPE_ETH || w.proto_type != PTYPE_IP4 ||
                   w.hw_len != HW_LEN || w.proto_len != PROTO_LEN) begin
        r.status = ST_BAD_FORMAT;
      end else if (w.arp_oper == OPER_REQ) begin
        // The reply goes back to the requester; the target address is not
        // compared with our own.
        cache_store(w.device, w.sender_ip, w.sender_mac, w.now);
        r.status = ST_REQ_ANSWERED;
        r.send_frame = 1'b1;
        r.frame_oper = FRAME_REP;
        r.frame_dest_mac = w.sender_mac;
        r.frame_target_mac = w.sender_mac;
        r.frame_sender_ip = w.target_ip;
        r.frame_target_ip = w.sender_ip;
      end else if (w.arp_oper == OPER_REP) begin
        cache_store(w.device, w.sender_ip, w.sender_mac, w.now);
        r.status = ST_REPLY_STORED;
      end else begin
        r.status = ST_UNKNOWN_OPER;
      end
      return 1'b1;
    end
    slot = cache_index_of(w.device, w.target_ip);
    if (w.command == CMD_LOOKUP) begin
      if (slot >= 0) begin
        r.status = ST_LOOKUP_HIT;
        r.found_mac = cache_mac[slot];
      end else begin
        r.status = ST_LOOKUP_MISS;
      end
    end else if (slot >= 0) begin
      r.status = ST_RESOLVE_HIT;
      r.found_mac = cache_mac[slot];
    end else begin
      r.status = ST_REQUEST_SENT;
      r.send_frame = 1'b1;
      r.frame_oper = FRAME_REQ;
      r.frame_dest_mac = MAC_BCAST;
      r.frame_sender_ip = own_ip_shadow;
      r.frame_target_ip = w.target_ip;
    end
    return 1'b1;
  endfunction

  function automatic arp_result_t status_only(input status_t s);
    arp_result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  // A receive word with a well-formed Ethernet/IPv4 header.
  function automatic arp_word_t rx_word(input logic [1:0] dev, input logic [15:0] plen,
                                        input logic [15:0] oper, input logic [47:0] smac,
                                        input logic [31:0] sip, input logic [31:0] tip,
                                        input logic [31:0] stamp);
    arp_word_t w;
    w.command = CMD_RECEIVE;
    w.device = dev;
    w.packet_length = plen;
    w.hw_type = HTYPE_ETH;
    w.proto_type = PTYPE_IP4;
    w.hw_len = HW_LEN;
    w.proto_len = PROTO_LEN;
    w.arp_oper = oper;
    w.sender_mac = smac;
    w.sender_ip = sip;
    w.target_ip = tip;
    w.now = stamp;
    return w;
  endfunction

  function automatic arp_word_t query_word(input logic [1:0] cmd, input logic [1:0] dev,
                                           input logic [31:0] ip);
    arp_word_t w;
    w = '0;
    w.command = cmd;
    w.device = dev;
    w.target_ip = ip;
    return w;
  endfunction

  // Mostly well-formed receive words and lookups of known keys with random
  // contents; the rest are short packets, damaged headers, odd operations,
  // fully random words and the unused command.
  function automatic arp_word_t random_word();
    arp_word_t w;
    arp_word_t good;
    int pick;
    int k;
    w.command = CMD_UNUSED;
    w.device = 2'($urandom);
    w.packet_length = 16'($urandom);
    w.hw_type = 16'($urandom);
    w.proto_type = 16'($urandom);
    w.hw_len = 8'($urandom);
    w.proto_len = 8'($urandom);
    w.arp_oper = 16'($urandom);
    w.sender_mac = {16'($urandom), 32'($urandom)};
    w.sender_ip = $urandom;
    w.target_ip = $urandom;
    tick += $urandom_range(0, 3);
    w.now = tick;
    case ($urandom_range(0, 19))
      0: w.now = $urandom;
      1: w.now = '1;
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, KEYS - 1);
      w.device = key_dev[k];
      w.sender_ip = key_ip[k];
    end
    if ($urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, KEYS - 1);
      w.target_ip = key_ip[k];
      if (pick >= 45)
        w.device = key_dev[k];
    end
    if (pick < 45) begin
      good = rx_word(w.device, 16'($urandom_range(HDR_BYTES, 16'hFFFF)),
                     $urandom_range(0, 1) ? OPER_REQ : OPER_REP,
                     w.sender_mac, w.sender_ip, w.target_ip, w.now);
      case ($urandom_range(0, 9))
        0: good.packet_length = 16'($urandom_range(0, HDR_BYTES - 1));
        1: begin
          case ($urandom_range(0, 3))
            0: good.hw_type = w.hw_type;
            1: good.proto_type = w.proto_type;
            2: good.hw_len = w.hw_len;
            default: good.proto_len = w.proto_len;
          endcase
        end
        2: good.arp_oper = w.arp_oper;
        3: begin
          good = w;
          good.command = CMD_RECEIVE;
        end
        default: ;
      endcase
      w = good;
    end else if (pick < 70) begin
      w.command = CMD_LOOKUP;
    end else if (pick < 95) begin
      w.command = CMD_RESOLVE;
    end
    return w;
  endfunction

  task automatic add_row(input arp_word_t w, input logic typed, input arp_result_t fixed);
    dir_rows.push_back({w, typed, fixed});
  endtask

  // Presents one word and holds it until the block takes it. The prediction
  // is made at the accepting edge, so words and results stay in order.
  task automatic send_word(input arp_word_t w, input logic typed, input arp_result_t fixed);
    arp_result_t r;
    @(negedge clk);
    in_command <= w.command;
    in_device <= w.device;
    in_packet_length <= w.packet_length;
    in_hw_type <= w.hw_type;
    in_proto_type <= w.proto_type;
    in_hw_len <= w.hw_len;
    in_proto_len <= w.proto_len;
    in_arp_oper <= w.arp_oper;
    in_sender_mac <= w.sender_mac;
    in_sender_ip <= w.sender_ip;
    in_target_ip <= w.target_ip;
    in_now <= w.now;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (predict_response(w, r))
      pending_results.push_back(typed ? fixed : r);
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Holds the sender off until every pending result has come back and any
  // trailing unused-command word has surely been retired.
  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the own address with a setup and an access cycle, then reads it back.
  task automatic set_own_ip(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= OWN_IP_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    own_ip_shadow = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value)
      flag_mismatch("own address read back", prdata, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker. Results cannot be held off, so every strobe is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, status", out_status, 0);
      end else begin
        arp_result_t want;
        want = pending_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", out_status, want.status);
        if (out_send_frame !== want.send_frame)
          flag_mismatch("send_frame", out_send_frame, want.send_frame);
        if (out_frame_oper !== want.frame_oper)
          flag_mismatch("frame_oper", out_frame_oper, want.frame_oper);
        if (out_frame_dest_mac !== want.frame_dest_mac)
          flag_mismatch("frame_dest_mac", out_frame_dest_mac, want.frame_dest_mac);
        if (out_frame_target_mac !== want.frame_target_mac)
          flag_mismatch("frame_target_mac", out_frame_target_mac, want.frame_target_mac);
        if (out_frame_sender_ip !== want.frame_sender_ip)
          flag_mismatch("frame_sender_ip", out_frame_sender_ip, want.frame_sender_ip);
        if (out_frame_target_ip !== want.frame_target_ip)
          flag_mismatch("frame_target_ip", out_frame_target_ip, want.frame_target_ip);
        if (out_found_mac !== want.found_mac)
          flag_mismatch("found_mac", out_found_mac, want.found_mac);
      end
    end
  end

  // Ends a run in which neither a word nor a result has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    arp_word_t w;
    arp_result_t r;
    int i;
    int phase;
    int n;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    in_command = CMD_RECEIVE;
    in_device = '0;
    in_packet_length = '0;
    in_hw_type = '0;
    in_proto_type = '0;
    in_hw_len = '0;
    in_proto_len = '0;
    in_arp_oper = '0;
    in_sender_mac = '0;
    in_sender_ip = '0;
    in_target_ip = '0;
    in_now = '0;
    mismatch_count = 0;
    results_seen = 0;
    quiet_cycles = 0;
    own_ip_shadow = '0;
    tick = $urandom_range(0, 1000);
    for (i = 0; i < CACHE_ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_dev[i] = '0;
      cache_ip[i] = '0;
      cache_mac[i] = '0;
      cache_stamp[i] = '0;
    end
    for (i = 0; i < KEYS; i++) begin
      key_dev[i] = 2'($urandom);
      key_ip[i] = $urandom;
    end
    key_ip[0] = '0;
    key_ip[1] = '1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The cache is empty and the own address is zero after reset.
    add_row(query_word(CMD_LOOKUP, 2'd0, 32'h0), 1'b1, status_only(ST_LOOKUP_MISS));
    r = status_only(ST_REQUEST_SENT);
    r.send_frame = 1'b1;
    r.frame_oper = FRAME_REQ;
    r.frame_dest_mac = MAC_BCAST;
    r.frame_sender_ip = '0;
    r.frame_target_ip = '1;
    add_row(query_word(CMD_RESOLVE, 2'd3, '1), 1'b1, r);

    // Rejected receive words: short packets, each header field wrong in
    // turn, and operations that are neither request nor reply.
    w = rx_word(2'd1, 16'd0, OPER_REQ, 48'h0200_0000_0001, 32'hC0A8_0001,
                32'hC0A8_0002, 32'd5);
    add_row(w, 1'b1, status_only(ST_TOO_SHORT));
    w.packet_length = HDR_BYTES - 1;
    add_row(w, 1'b1, status_only(ST_TOO_SHORT));
    w.packet_length = HDR_BYTES;
    w.hw_type = 16'hFFFF;
    add_row(w, 1'b1, status_only(ST_BAD_FORMAT));
    w.hw_type = HTYPE_ETH;
    w.proto_type = 16'h86DD;
    add_row(w, 1'b1, status_only(ST_BAD_FORMAT));
    w.proto_type = PTYPE_IP4;
    w.hw_len = 8'hFF;
    add_row(w, 1'b1, status_only(ST_BAD_FORMAT));
    w.hw_len = HW_LEN;
    w.proto_len = 8'h00;
    add_row(w, 1'b1, status_only(ST_BAD_FORMAT));
    w.proto_len = PROTO_LEN;
    w.arp_oper = 16'h0000;
    add_row(w, 1'b1, status_only(ST_UNKNOWN_OPER));
    w.arp_oper = 16'hFFFF;
    add_row(w, 1'b1, status_only(ST_UNKNOWN_OPER));

    // Stores at the field extremes, then hits, the unused command, and the
    // same address under another device number.
    add_row(rx_word(2'd3, 16'hFFFF, OPER_REQ, '1, '1, '0, '1), 1'b0, '0);
    add_row(rx_word(2'd0, HDR_BYTES, OPER_REP, '0, '0, '1, '0), 1'b0, '0);
    add_row(query_word(CMD_LOOKUP, 2'd3, '1), 1'b0, '0);
    add_row(query_word(CMD_RESOLVE, 2'd0, '0), 1'b0, '0);
    add_row(query_word(CMD_UNUSED, 2'd2, '0), 1'b0, '0);
    add_row(query_word(CMD_LOOKUP, 2'd1, '1), 1'b0, '0);

    // Refresh an existing entry, fill the cache with maximal stamps, then
    // store a new key: with every stamp at its maximum slot 0 is replaced.
    add_row(rx_word(2'd0, 16'd60, OPER_REP, 48'h0123_4567_89AB, '0, '0, '1), 1'b0, '0);
    for (n = 1; n <= 6; n++)
      add_row(rx_word(2'd2, 16'd42, OPER_REP, 48'h0A00_0000_0000 + n, n, '0, '1),
              1'b0, '0);
    add_row(rx_word(2'd1, 16'd42, OPER_REQ, 48'h0B00_0000_0001, 32'h0A00_0001,
                    32'h0A00_00FE, '1), 1'b0, '0);
    add_row(query_word(CMD_LOOKUP, 2'd3, '1), 1'b0, '0);
    add_row(query_word(CMD_LOOKUP, 2'd1, 32'h0A00_0001), 1'b0, '0);

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].fixed);

    // Random part in phases, each under its own address setting. The last
    // phase runs with no gaps at all.
    for (phase = 0; phase < 4; phase++) begin
      wait_until_drained();
      case (phase)
        0: set_own_ip('1);
        1: set_own_ip('0);
        default: set_own_ip($urandom);
      endcase
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (phase < 3) begin
          if (n == PHASE_WORDS / 2 || $urandom_range(0, 59) == 0)
            wait_until_drained();
          else if ($urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 13));
        end
        send_word(random_word(), 1'b0, '0);
      end
    end
    wait_until_drained();

    if (pending_results.size() != 0)
      flag_mismatch("results never returned", pending_results.size(), 0);
    if (mismatch_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
